@@ hdl/drac_pkg.sv @@
// Package with shared constants, codes and types of the depth range auto contrast block.
package drac_pkg;

  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam int unsigned PLANE_WIDTH   = 16;
  localparam int unsigned CFG_IDX_WIDTH = 1;
  localparam int unsigned COLOR_WIDTH   = 8;
  localparam int unsigned QUOT_BITS     = 8;
  localparam int unsigned CNT_WIDTH     = $clog2(QUOT_BITS);

  localparam logic [PLANE_WIDTH-1:0] MIN_PLANE_RST = 16'hF000;
  localparam logic [PLANE_WIDTH-1:0] MAX_PLANE_RST = 16'h1000;

  localparam logic [COLOR_WIDTH-1:0] DIM_LEVEL  = 8'd64;
  localparam logic [COLOR_WIDTH-1:0] FULL_SCALE = 8'd255;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_PLANE = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_PLANE = 1'b1;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] red;
    logic [COLOR_WIDTH-1:0] green;
    logic [COLOR_WIDTH-1:0] blue;
  } color_t;

endpackage

@@ hdl/drac_in_if.sv @@
// Input sample channel: valid/ready handshake with op, frame start and sample.
interface drac_in_if #(
  parameter int unsigned SAMPLE_WIDTH = drac_pkg::SAMPLE_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic                    frame_start;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output op, output frame_start, output sample, input ready);
  modport sink   (input valid, input op, input frame_start, input sample, output ready);
endinterface

@@ hdl/drac_out_if.sv @@
// Output color channel: valid/ready handshake with red, green and blue.
interface drac_out_if;
  logic                             valid;
  logic                             ready;
  logic [drac_pkg::COLOR_WIDTH-1:0] red;
  logic [drac_pkg::COLOR_WIDTH-1:0] green;
  logic [drac_pkg::COLOR_WIDTH-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hdl/depth_range_auto_contrast.sv @@
// Measure beats are accepted back to back; ready stays high through a measure run.
// A convert beat inside the window and the measured range passes through classify, divider
// setup, eight restoring divider steps and the output load before its result is valid.
// Other convert beats go from classify straight to the output load. Ready returns in the
// cycle after the result is loaded; a result waiting on a full output register holds off
// the input until the output is taken.
// Reset (rst_ni low, asynchronous) sets the window to [-4096, 4096] and empties the range.
module depth_range_auto_contrast #(
  parameter int unsigned SAMPLE_WIDTH = drac_pkg::SAMPLE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [drac_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [drac_pkg::PLANE_WIDTH-1:0]   cfg_data_i,
  drac_in_if.sink                            in_if,
  drac_out_if.source                         out_if
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = drac_pkg::PLANE_WIDTH;
  localparam int unsigned QB = drac_pkg::QUOT_BITS;
  localparam int unsigned CNTW = drac_pkg::CNT_WIDTH;
  localparam int unsigned CW = ((SW > PW) ? SW : PW) + 1;
  localparam int unsigned XW = SW + QB;
  localparam logic [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  drac_pkg::state_e state_q, state_d;

  logic [PW-1:0]   min_plane_q, max_plane_q;
  logic [SW-1:0]   seen_low_q, seen_high_q;
  logic [SW-1:0]   v_q;
  logic [SW-1:0]   num_q, den_q, rem_q;
  logic [QB-1:0]   xlo_q, quo_q;
  logic [CNTW-1:0] cnt_q;
  drac_pkg::color_t res_q, out_q;
  logic            out_valid_q;

  logic accept, measure_acc, convert_acc, out_load, div_last;

  // Window test on the incoming sample, used by the measure pass.
  logic signed [CW-1:0] in_ext, min_ext, max_ext, v_ext;
  logic                 in_win;
  logic [SW-1:0]        lo_base, hi_base;

  assign in_ext  = {{(CW-SW){in_if.sample[SW-1]}}, in_if.sample};
  assign min_ext = {{(CW-PW){min_plane_q[PW-1]}}, min_plane_q};
  assign max_ext = {{(CW-PW){max_plane_q[PW-1]}}, max_plane_q};
  assign in_win  = (in_ext >= min_ext) && (in_ext <= max_ext);
  assign lo_base = in_if.frame_start ? MOST_POS : seen_low_q;
  assign hi_base = in_if.frame_start ? MOST_NEG : seen_high_q;

  // Classification of the registered convert sample.
  logic              below, above, range_ok, num_pos, sat, calc_div;
  logic [SW:0]       num_full, den_full;
  assign v_ext    = {{(CW-SW){v_q[SW-1]}}, v_q};
  assign below    = v_ext < min_ext;
  assign above    = v_ext > max_ext;
  assign range_ok = $signed(seen_high_q) > $signed(seen_low_q);
  assign num_full = {v_q[SW-1], v_q} - {seen_low_q[SW-1], seen_low_q};
  assign den_full = {seen_high_q[SW-1], seen_high_q} - {seen_low_q[SW-1], seen_low_q};
  assign num_pos  = !num_full[SW] && (num_full != '0);
  // A sample at or above the top of the range gives a ratio of at least full scale.
  assign sat      = $signed(v_q) >= $signed(seen_high_q);
  assign calc_div = !below && !above && range_ok && num_pos && !sat;

  // Color of a convert beat that needs no division.
  drac_pkg::color_t calc_res;
  always_comb begin
    calc_res = '0;
    if (below) begin
      calc_res.green = drac_pkg::DIM_LEVEL;
    end else if (above) begin
      calc_res.red = drac_pkg::DIM_LEVEL;
    end else if (range_ok && num_pos && sat) begin
      calc_res.blue = drac_pkg::FULL_SCALE;
    end
  end

  // Dividend num * 255 as (num << 8) - num.
  logic [XW-1:0] x_full;
  assign x_full = {num_q, {QB{1'b0}}} - {{QB{1'b0}}, num_q};

  // One restoring step: bring down the next dividend bit and try the subtract.
  logic [SW:0]   trial_rem;
  logic [SW+1:0] trial_diff;
  logic          trial_ge;
  assign trial_rem  = {rem_q, xlo_q[QB-1]};
  assign trial_diff = {1'b0, trial_rem} - {2'b00, den_q};
  assign trial_ge   = !trial_diff[SW+1];
  assign div_last   = cnt_q == CNTW'(QB-1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drac_pkg::ST_IDLE: begin
        if (convert_acc) begin
          state_d = drac_pkg::ST_CALC;
        end
      end
      drac_pkg::ST_CALC: begin
        state_d = calc_div ? drac_pkg::ST_PREP : drac_pkg::ST_DONE;
      end
      drac_pkg::ST_PREP: begin
        state_d = drac_pkg::ST_DIV;
      end
      drac_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = drac_pkg::ST_DONE;
        end
      end
      drac_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = drac_pkg::ST_IDLE;
        end
      end
      default: state_d = drac_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_if.ready  = state_q == drac_pkg::ST_IDLE;
    accept       = in_if.valid && in_if.ready;
    measure_acc  = accept && (in_if.op == drac_pkg::OP_MEASURE);
    convert_acc  = accept && (in_if.op == drac_pkg::OP_CONVERT);
    out_load     = (state_q == drac_pkg::ST_DONE) && (!out_valid_q || out_if.ready);
    out_if.valid = out_valid_q;
    out_if.red   = out_q.red;
    out_if.green = out_q.green;
    out_if.blue  = out_q.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drac_pkg::ST_IDLE;
      min_plane_q <= drac_pkg::MIN_PLANE_RST;
      max_plane_q <= drac_pkg::MAX_PLANE_RST;
      seen_low_q  <= MOST_POS;
      seen_high_q <= MOST_NEG;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          drac_pkg::REG_MIN_PLANE: min_plane_q <= cfg_data_i;
          drac_pkg::REG_MAX_PLANE: max_plane_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (measure_acc) begin
        seen_low_q  <= (in_win && ($signed(in_if.sample) < $signed(lo_base)))
                       ? in_if.sample : lo_base;
        seen_high_q <= (in_win && ($signed(in_if.sample) > $signed(hi_base)))
                       ? in_if.sample : hi_base;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == drac_pkg::ST_DIV) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (convert_acc) begin
      v_q <= in_if.sample;
    end
    if (out_load) begin
      out_q <= res_q;
    end
    unique case (state_q)
      drac_pkg::ST_CALC: begin
        res_q <= calc_res;
        num_q <= num_full[SW-1:0];
        den_q <= den_full[SW-1:0];
      end
      drac_pkg::ST_PREP: begin
        rem_q <= x_full[XW-1:QB];
        xlo_q <= x_full[QB-1:0];
        quo_q <= '0;
      end
      drac_pkg::ST_DIV: begin
        rem_q <= trial_ge ? trial_diff[SW-1:0] : trial_rem[SW-1:0];
        xlo_q <= {xlo_q[QB-2:0], 1'b0};
        quo_q <= {quo_q[QB-2:0], trial_ge};
        if (div_last) begin
          res_q.blue <= {quo_q[QB-2:0], trial_ge};
        end
      end
      default: ;
    endcase
  end

  // A convert beat always starts the classification step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    convert_acc |=> (state_q == drac_pkg::ST_CALC))
    else $error("convert beat did not start classification");

  // The step counter runs only during the division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != drac_pkg::ST_DIV) |-> (cnt_q == '0))
    else $error("divider step counter out of step");

  // An in-window measure sample leaves a non-empty range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (measure_acc && in_win) |=> ($signed(seen_high_q) >= $signed(seen_low_q)))
    else $error("measured range inverted after in-window sample");

  // A result carries at most one meaningful channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ($countones({out_if.red != '0, out_if.green != '0,
                                  out_if.blue != '0}) <= 1))
    else $error("more than one color channel set");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the depth range auto contrast block: predictor, driver, monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW            = drac_pkg::SAMPLE_WIDTH;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS   = 200;

  typedef struct packed {
    logic          op;
    logic          frame_start;
    logic [SW-1:0] sample;
  } depth_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [drac_pkg::CFG_IDX_WIDTH-1:0] cfg_idx;
  logic [drac_pkg::PLANE_WIDTH-1:0]   cfg_data;

  drac_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
  drac_out_if                     out_ch ();

  depth_range_auto_contrast #(.SAMPLE_WIDTH(SW)) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: window registers and the measured depth range.
  logic signed [drac_pkg::PLANE_WIDTH-1:0] win_lo;
  logic signed [drac_pkg::PLANE_WIDTH-1:0] win_hi;
  logic signed [SW-1:0]                    range_lo;
  logic signed [SW-1:0]                    range_hi;

  depth_beat_t      pending_beats[$];
  drac_pkg::color_t expected_colors[$];

  int  n_queued;
  int  n_accepted;
  int  n_results;
  int  n_mismatch;
  int  n_measure;
  int  n_convert;
  int  n_green;
  int  n_red;
  int  n_scaled;
  int  n_cfg_writes;
  bit  idle_enable;
  logic sink_hold;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_s16();
    logic [15:0] x;
    x = 16'($urandom);
    return int'($signed(x));
  endfunction

  function automatic void clear_range();
    range_lo = {1'b0, {(SW-1){1'b1}}};
    range_hi = {1'b1, {(SW-1){1'b0}}};
  endfunction

  function automatic drac_pkg::color_t depth_to_color(input logic signed [SW-1:0] v);
    drac_pkg::color_t c;
    longint num;
    longint den;
    longint q;
    c = '0;
    if (v < win_lo) begin
      c.green = drac_pkg::DIM_LEVEL;
      n_green++;
    end else if (v > win_hi) begin
      c.red = drac_pkg::DIM_LEVEL;
      n_red++;
    end else begin
      n_scaled++;
      // An empty or flat range leaves blue at zero.
      if (range_hi > range_lo) begin
        num = longint'(v) - longint'(range_lo);
        den = longint'(range_hi) - longint'(range_lo);
        if (num > 0) begin
          q = (num * longint'(drac_pkg::FULL_SCALE)) / den;
          c.blue = (q > longint'(drac_pkg::FULL_SCALE)) ? drac_pkg::FULL_SCALE
                                                        : q[drac_pkg::COLOR_WIDTH-1:0];
        end
      end
    end
    return c;
  endfunction

  function automatic void predict_beat(input logic op, input logic fs, input logic [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = s;
    if (op == drac_pkg::OP_CONVERT) begin
      n_convert++;
      expected_colors.push_back(depth_to_color(v));
    end else begin
      n_measure++;
      if (fs) clear_range();
      if (v >= win_lo && v <= win_hi) begin
        if (v < range_lo) range_lo = v;
        if (v > range_hi) range_hi = v;
      end
    end
  endfunction

  task automatic note_mismatch(input string field, input int expv, input int gotv);
    if (n_mismatch < 10) begin
      $display("MISMATCH result %0d %s: expected %0d, got %0d", n_results, field, expv, gotv);
    end
    n_mismatch++;
  endtask

  task automatic check_color(input drac_pkg::color_t got);
    drac_pkg::color_t want;
    if (expected_colors.size() == 0) begin
      if (n_mismatch < 10) begin
        $display("MISMATCH result %0d arrived with no color pending: r=%0d g=%0d b=%0d",
                 n_results, got.red, got.green, got.blue);
      end
      n_mismatch++;
    end else begin
      want = expected_colors.pop_front();
      if (got.red !== want.red) begin
        note_mismatch("red", int'(want.red), int'(got.red));
      end
      if (got.green !== want.green) begin
        note_mismatch("green", int'(want.green), int'(got.green));
      end
      if (got.blue !== want.blue) begin
        note_mismatch("blue", int'(want.blue), int'(got.blue));
      end
    end
    n_results++;
  endtask

  // Sample driver: presents queued beats with random gaps between them.
  always @(posedge clk_i) begin : sample_driver
    int gap_left;
    depth_beat_t nb;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_beat(in_ch.op, in_ch.frame_start, in_ch.sample);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          in_ch.op          <= nb.op;
          in_ch.frame_start <= nb.frame_start;
          in_ch.sample      <= nb.sample;
          in_ch.valid       <= 1'b1;
          if (idle_enable) gap_left = draw_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Color monitor: checks each color taken from the output and stalls ready at random.
  always @(posedge clk_i) begin : color_monitor
    int stall_left;
    drac_pkg::color_t got;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.red   = out_ch.red;
        got.green = out_ch.green;
        got.blue  = out_ch.blue;
        check_color(got);
        if (idle_enable) stall_left = draw_gap();
      end
      if (idle_enable && stall_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !sink_hold;
      end
    end
  end

  // One long hold-off on the color side while plenty of samples are still queued.
  initial begin : sink_holdoff
    sink_hold = 1'b0;
    do @(posedge clk_i);
    while (!(n_accepted >= 700 && pending_beats.size() >= 40));
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    #10000000;
    $display("Timeout with %0d colors still pending", expected_colors.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_beat(input logic op, input logic fs, input int v);
    depth_beat_t b;
    b.op          = op;
    b.frame_start = fs;
    b.sample      = v[SW-1:0];
    pending_beats.push_back(b);
    n_queued++;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (n_accepted != n_queued || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [drac_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [drac_pkg::PLANE_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == drac_pkg::REG_MIN_PLANE) win_lo = val;
    else win_hi = val;
    n_cfg_writes++;
  endtask

  task automatic set_window(input int lo, input int hi);
    cfg_write(drac_pkg::REG_MIN_PLANE, lo[drac_pkg::PLANE_WIDTH-1:0]);
    cfg_write(drac_pkg::REG_MAX_PLANE, hi[drac_pkg::PLANE_WIDTH-1:0]);
  endtask

  function automatic int pick_sample(input int lo, input int hi);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 70 && lo <= hi) begin
      v = lo + int'($urandom_range(0, hi - lo));
    end else if (r < 85) begin
      v = (r[0] ? lo : hi) + int'($urandom_range(0, 6)) - 3;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
    end else begin
      v = rand_s16();
    end
    return v;
  endfunction

  // A well-formed frame: a measure run opened by frame start, then a convert run.
  task automatic queue_frame(input int lo, input int hi);
    int n_meas;
    int n_conv;
    n_meas = $urandom_range(1, 24);
    n_conv = $urandom_range(1, 24);
    for (int i = 0; i < n_meas; i++) begin
      queue_beat(drac_pkg::OP_MEASURE, i == 0, pick_sample(lo, hi));
    end
    for (int i = 0; i < n_conv; i++) begin
      queue_beat(drac_pkg::OP_CONVERT, 1'($urandom_range(0, 1)), pick_sample(lo, hi));
    end
  endtask

  task automatic pick_window(output int lo, output int hi);
    int a;
    int b;
    int r;
    r = $urandom_range(0, 11);
    a = rand_s16();
    b = rand_s16();
    unique case (r)
      0: begin
        lo = -4096;
        hi = 4096;
      end
      1: begin
        lo = -32768;
        hi = 32767;
      end
      2: begin
        // Inverted window.
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
        if (lo == hi) lo = (hi < 32767) ? hi + 1 : hi - 1;
        if (lo < hi) begin
          a = lo;
          lo = hi;
          hi = a;
        end
      end
      3: begin
        lo = $urandom_range(0, 65000) - 32768;
        hi = lo + $urandom_range(0, 40);
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
  endtask

  initial begin : stimulus
    int lo;
    int hi;
    int target;
    int r;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = drac_pkg::REG_MIN_PLANE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = drac_pkg::OP_MEASURE;
    in_ch.frame_start = 1'b0;
    in_ch.sample      = '0;
    out_ch.ready      = 1'b0;
    win_lo            = drac_pkg::MIN_PLANE_RST;
    win_hi            = drac_pkg::MAX_PLANE_RST;
    clear_range();
    idle_enable = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: empty range, window edges, out-of-range and flat cases.
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, -32768);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 32767);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, -2000);
    queue_beat(drac_pkg::OP_MEASURE, 1'b0, 5000);
    queue_beat(drac_pkg::OP_MEASURE, 1'b0, -4096);
    queue_beat(drac_pkg::OP_MEASURE, 1'b0, 4096);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, -4096);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 4096);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, -4097);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 4097);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, -1000);
    queue_beat(drac_pkg::OP_MEASURE, 1'b0, 1000);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, -2000);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 3000);
    queue_beat(drac_pkg::OP_CONVERT, 1'b1, 500);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, 100);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 100);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 200);
    settle();

    // Full-scale window.
    set_window(-32768, 32767);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, -32768);
    queue_beat(drac_pkg::OP_MEASURE, 1'b0, 32767);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 32767);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 1);
    settle();

    // Inverted window: nothing is measured, converts are green or red only.
    set_window(1000, -1000);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 1000);
    settle();

    // Single-point window gives a flat range.
    set_window(0, 0);
    queue_beat(drac_pkg::OP_MEASURE, 1'b1, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, 0);
    queue_beat(drac_pkg::OP_CONVERT, 1'b0, -1);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_enable = (ph != 1);
      pick_window(lo, hi);
      if (ph == 0) begin
        lo = -32768;
        hi = 32767;
      end
      set_window(lo, hi);
      target = n_queued + PHASE_BEATS;
      while (n_queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          queue_frame(lo, hi);
        end else if (r < 88) begin
          // Noise: any op, any flag, any sample.
          repeat ($urandom_range(1, 5)) begin
            queue_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_s16());
          end
        end else if (r < 96) begin
          // Broken sequence: converts or a measure run with no frame start.
          repeat ($urandom_range(1, 8)) begin
            queue_beat(1'(r[0]), 1'b0, pick_sample(lo, hi));
          end
        end else begin
          // Sender waits for every pending color before going on.
          settle();
        end
      end
      settle();
    end

    $display("Ran %0d measure and %0d convert beats across %0d register writes.",
             n_measure, n_convert, n_cfg_writes);
    $display("Colors checked: %0d green, %0d red, %0d scaled in-window, %0d mismatches.",
             n_green, n_red, n_scaled, n_mismatch);
    if (n_mismatch == 0 && expected_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
